[sv/sitda_pkg.sv]
`timescale 1ns / 1ps

package sitda_pkg;

  // Input width and derived conversion sizes
  localparam int VALUE_WIDTH = 32;
  localparam int DIGIT_BITS  = 4;
  localparam int STEP_BITS   = 4;
  localparam int STEPS       = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W       = STEPS * STEP_BITS;
  localparam int NDIG        = (VALUE_WIDTH * 3) / 10 + 1;
  localparam int BCD_W       = NDIG * DIGIT_BITS;
  localparam int IDX_W       = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int STEP_W      = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CODE_W      = 6;

  // ASCII codes
  localparam logic [CODE_W-1:0] ASCII_ZERO  = CODE_W'(48);
  localparam logic [CODE_W-1:0] ASCII_MINUS = CODE_W'(45);

  // Double-dabble correction: digits of 5 or more get 3 added before the shift
  localparam logic [DIGIT_BITS-1:0] DD_THRESH = DIGIT_BITS'(5);
  localparam logic [DIGIT_BITS-1:0] DD_ADJ    = DIGIT_BITS'(3);

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture magnitude and sign, clear BCD
    logic step;      // one multi-bit double-dabble step
    logic scan;      // latch index of leading nonzero digit
    logic dec;       // advance to next lower digit
    logic sel_sign;  // character output shows the minus sign
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic neg;       // captured value was negative
    logic idx_zero;  // current digit is the least significant one
  } sts_t;

endpackage

[sv/signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps

// Converts one signed two's-complement integer to decimal ASCII, one character
// per output transfer: a leading '-' (45) for negative values, then digits
// (48..57) most significant first, no leading zeros, zero giving "0";
// out_last_char marks the final character. The most negative value prints
// correctly. One number is handled at a time: after the input transfer the
// binary-to-BCD unit converts 4 bits per cycle over 32 bits, a scan state
// finds the leading digit, then the characters follow, each waiting until
// the output side accepts it. in_ready is high only while no number is in
// progress.
module signed_int_to_decimal_ascii (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic [sitda_pkg::CODE_W-1:0]             out_char_code,
  output logic                                     out_last_char
);

  sitda_pkg::cmd_t cmd;
  sitda_pkg::sts_t sts;

  // Sequencer
  sitda_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_last_char (out_last_char),
    .cmd           (cmd),
    .sts           (sts)
  );

  // Magnitude, BCD conversion and character select
  sitda_dp u_dp (
    .clk       (clk),
    .in_value  (in_value),
    .cmd       (cmd),
    .sts       (sts),
    .char_code (out_char_code)
  );

endmodule

[sv/sitda_dp.sv]
`timescale 1ns / 1ps

module sitda_dp (
  input  logic                                   clk,
  input  logic signed [sitda_pkg::VALUE_WIDTH-1:0] in_value,
  input  sitda_pkg::cmd_t                        cmd,
  output sitda_pkg::sts_t                        sts,
  output logic [sitda_pkg::CODE_W-1:0]           char_code
);

  logic [sitda_pkg::PAD_W-1:0]       mag_r, mag_nxt;
  logic [sitda_pkg::BCD_W-1:0]       bcd_r, bcd_nxt;
  logic [sitda_pkg::IDX_W-1:0]       idx_r, idx_nxt;
  logic                              neg_r, neg_nxt;
  logic [sitda_pkg::VALUE_WIDTH-1:0] mag_w;
  logic [sitda_pkg::PAD_W-1:0]       mag_v;
  logic [sitda_pkg::BCD_W-1:0]       bcd_v;
  logic [sitda_pkg::IDX_W-1:0]       top_idx;
  logic [sitda_pkg::DIGIT_BITS-1:0]  dig;

  // Unsigned magnitude; the most negative value maps to 2^(W-1)
  assign mag_w = in_value[sitda_pkg::VALUE_WIDTH-1] ?
                 (~in_value) + sitda_pkg::VALUE_WIDTH'(1) : in_value;

  // Double dabble, STEP_BITS bits per cycle
  always_comb begin
    bcd_v = bcd_r;
    mag_v = mag_r;
    for (int b = 0; b < sitda_pkg::STEP_BITS; b++) begin
      for (int d = 0; d < sitda_pkg::NDIG; d++) begin
        if (bcd_v[d*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS] >= sitda_pkg::DD_THRESH) begin
          bcd_v[d*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS] =
            bcd_v[d*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS] + sitda_pkg::DD_ADJ;
        end
      end
      {bcd_v, mag_v} = {bcd_v[sitda_pkg::BCD_W-2:0], mag_v, 1'b0};
    end
  end

  // Highest nonzero digit, zero when the value is zero
  always_comb begin
    top_idx = '0;
    for (int d = 0; d < sitda_pkg::NDIG; d++) begin
      if (bcd_r[d*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS] != '0) begin
        top_idx = sitda_pkg::IDX_W'(d);
      end
    end
  end

  // Next-state selection
  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    idx_nxt = idx_r;
    neg_nxt = neg_r;
    if (cmd.load) begin
      mag_nxt = sitda_pkg::PAD_W'(mag_w);
      bcd_nxt = '0;
      neg_nxt = in_value[sitda_pkg::VALUE_WIDTH-1];
    end else if (cmd.step) begin
      mag_nxt = mag_v;
      bcd_nxt = bcd_v;
    end
    if (cmd.scan) begin
      idx_nxt = top_idx;
    end else if (cmd.dec) begin
      idx_nxt = idx_r - sitda_pkg::IDX_W'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    idx_r <= idx_nxt;
    neg_r <= neg_nxt;
  end

  // Character output
  assign dig       = bcd_r[idx_r*sitda_pkg::DIGIT_BITS +: sitda_pkg::DIGIT_BITS];
  assign char_code = cmd.sel_sign ? sitda_pkg::ASCII_MINUS
                                  : sitda_pkg::ASCII_ZERO + sitda_pkg::CODE_W'(dig);

  assign sts.neg      = neg_r;
  assign sts.idx_zero = (idx_r == '0);

endmodule

[sv/sitda_ctrl.sv]
`timescale 1ns / 1ps

module sitda_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_last_char,
  output sitda_pkg::cmd_t cmd,
  input  sitda_pkg::sts_t sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CONV  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_DIGIT = 3'd4;

  logic [2:0]                   state_r, state_nxt;
  logic [sitda_pkg::STEP_W-1:0] cnt_r, cnt_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    out_last_char = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + sitda_pkg::STEP_W'(1);
        if (cnt_r == sitda_pkg::STEP_W'(sitda_pkg::STEPS - 1)) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan  = 1'b1;
        state_nxt = sts.neg ? S_SIGN : S_DIGIT;
      end
      S_SIGN: begin
        cmd.sel_sign = 1'b1;
        out_valid    = 1'b1;
        if (out_ready) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        out_valid     = 1'b1;
        out_last_char = sts.idx_zero;
        if (out_ready) begin
          if (sts.idx_zero) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.dec = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

[bench/tb_signed_int_to_decimal_ascii.sv]
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 40;

  // Expected ASCII text of every accepted number, in transfer order
  class ascii_scoreboard;
    typedef struct packed {
      logic [sitda_pkg::CODE_W-1:0] code;
      logic                         last;
    } char_t;

    char_t expected_chars[$];
    int    errors = 0;

    // Queue the characters for one accepted number
    function void note_value(logic [sitda_pkg::VALUE_WIDTH-1:0] value);
      logic [sitda_pkg::VALUE_WIDTH-1:0] mag;
      byte unsigned                      digits[$];
      char_t                             c;
      mag = value[sitda_pkg::VALUE_WIDTH-1] ? -value : value;
      do begin
        digits.push_front(byte'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      if (value[sitda_pkg::VALUE_WIDTH-1]) begin
        c.code = sitda_pkg::ASCII_MINUS;
        c.last = 1'b0;
        expected_chars.push_back(c);
      end
      foreach (digits[i]) begin
        c.code = sitda_pkg::CODE_W'(sitda_pkg::ASCII_ZERO + digits[i]);
        c.last = (i == digits.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    // Compare one output transfer with the oldest expected character
    function void check_char(logic [sitda_pkg::CODE_W-1:0] code, logic last);
      char_t c;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected char: expected none, actual code %0d last %0b",
                 $time, code, last);
        errors++;
        return;
      end
      c = expected_chars.pop_front();
      if (code !== c.code) begin
        $display("%0t: char_code mismatch: expected %0d, actual %0d", $time, c.code, code);
        errors++;
      end
      if (last !== c.last) begin
        $display("%0t: last_char mismatch: expected %0b, actual %0b", $time, c.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                                     clk = 1'b0;
  logic                                     rst_n = 1'b0;
  logic                                     in_valid = 1'b0;
  logic                                     in_ready;
  logic signed [sitda_pkg::VALUE_WIDTH-1:0] in_value = '0;
  logic                                     out_valid;
  logic                                     out_ready = 1'b0;
  logic [sitda_pkg::CODE_W-1:0]             out_char_code;
  logic                                     out_last_char;

  ascii_scoreboard sb = new();

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int cycles = 0;

  signed_int_to_decimal_ascii dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last_char(out_last_char)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Output side: check each transfer, then pick next ready (long hold on request)
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_char(out_char_code, out_last_char);
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Offer one number, with random idle cycles ahead of it
  task automatic send_value(logic [sitda_pkg::VALUE_WIDTH-1:0] value);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    sb.note_value(value);
  endtask

  // Mostly values of a chosen digit count, plus raw words and extremes
  function automatic logic [sitda_pkg::VALUE_WIDTH-1:0] random_value();
    int unsigned kind;
    int unsigned ndig;
    longint      lo;
    longint      hi;
    longint      mag;
    kind = $urandom_range(0, 9);
    if (kind < 3)
      return $urandom();
    if (kind == 9) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000 + $urandom_range(0, 3);
        1:       return 32'h7fff_ffff - $urandom_range(0, 3);
        2:       return $urandom_range(0, 2) - 1;
        default: return 32'h8000_0000;
      endcase
    end
    ndig = $urandom_range(1, 10);
    lo = (ndig == 1) ? 0 : 64'd10 ** (ndig - 1);
    hi = 64'd10 ** ndig - 1;
    if (hi > 64'h7fff_ffff)
      hi = 64'h7fff_ffff;
    mag = lo + $urandom_range(0, int'(hi - lo));
    if ($urandom_range(0, 1))
      mag = -mag;
    return sitda_pkg::VALUE_WIDTH'(mag);
  endfunction

  task automatic run_phase(int idle_pct, int stall_pct, int count);
    send_idle_pct = idle_pct;
    recv_stall_pct <= stall_pct;
    repeat (count) send_value(random_value());
  endtask

  logic [sitda_pkg::VALUE_WIDTH-1:0] directed[$] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001, 32'd999999999, 32'd1000000000,
    -32'sd1000000000, 32'd123456789, -32'sd987654321, 32'h5555_5555,
    32'haaaa_aaaa, 32'd2000000000, 32'd1234567890
  };

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed values, no idling
    foreach (directed[i]) send_value(directed[i]);

    run_phase(0, 0, 15);
    run_phase(46, 0, 15);
    run_phase(0, 46, 15);
    run_phase(15, 15, 15);

    // Receiver holds off while the sender keeps offering
    send_idle_pct  = 0;
    recv_stall_pct <= 0;
    hold_req       <= hold_req + 1;
    repeat (10) send_value(random_value());

    run_phase(0, 0, 10);
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
